// ===== rtl/dmc_pkg.sv =====
// Package: shared widths, codes, control structs and DEFLATE code tables.
package dmc_pkg;

  // History window and result packing
  localparam int WINDOW_SIZE      = 32768;
  localparam int ADDR_W           = $clog2(WINDOW_SIZE);
  localparam int COUNT_W          = ADDR_W + 1;
  localparam int BYTES_PER_RESULT = 8;
  localparam int LANE_W           = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

  // Field widths
  localparam int LIT_W        = 8;
  localparam int LSYM_W       = 9;
  localparam int LEXT_W       = 5;
  localparam int DSYM_W       = 5;
  localparam int DEXT_W       = 13;
  localparam int LEN_W        = 9;
  localparam int DIST_W       = 16;
  localparam int OUT_BYTES_W  = 64;
  localparam int BYTE_CNT_W   = 4;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 72;

  // Symbol codes
  localparam logic [LSYM_W-1:0] SYM_EOB       = 9'd256;
  localparam logic [LSYM_W-1:0] SYM_LEN_FIRST = 9'd257;
  localparam logic [LSYM_W-1:0] SYM_LEN_LAST  = 9'd285;
  localparam logic [DSYM_W-1:0] NUM_DIST_SYM  = 5'd30;

  // Command codes carried in the input user field
  localparam logic CMD_LITERAL = 1'b0;
  localparam logic CMD_MATCH   = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_LEN  = 2'd1,
    ERR_DIST = 2'd2,
    ERR_FAR  = 2'd3
  } err_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic check;
    logic issue;
    logic take;
    logic emit;
  } dmc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_literal;
    logic single;
    logic too_far;
    logic issue_left;
    logic catch_final;
    logic catch_flush;
    logic out_free;
  } dmc_stat_t;

  // Step a window pointer with wrap
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == ADDR_W'(WINDOW_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [LEN_W-1:0] len_base(input logic [4:0] idx);
    unique case (idx)
      5'd0:  len_base = 9'd3;    5'd1:  len_base = 9'd4;
      5'd2:  len_base = 9'd5;    5'd3:  len_base = 9'd6;
      5'd4:  len_base = 9'd7;    5'd5:  len_base = 9'd8;
      5'd6:  len_base = 9'd9;    5'd7:  len_base = 9'd10;
      5'd8:  len_base = 9'd11;   5'd9:  len_base = 9'd13;
      5'd10: len_base = 9'd15;   5'd11: len_base = 9'd17;
      5'd12: len_base = 9'd19;   5'd13: len_base = 9'd23;
      5'd14: len_base = 9'd27;   5'd15: len_base = 9'd31;
      5'd16: len_base = 9'd35;   5'd17: len_base = 9'd43;
      5'd18: len_base = 9'd51;   5'd19: len_base = 9'd59;
      5'd20: len_base = 9'd67;   5'd21: len_base = 9'd83;
      5'd22: len_base = 9'd99;   5'd23: len_base = 9'd115;
      5'd24: len_base = 9'd131;  5'd25: len_base = 9'd163;
      5'd26: len_base = 9'd195;  5'd27: len_base = 9'd227;
      5'd28: len_base = 9'd258;
      default: len_base = 9'd0;
    endcase
  endfunction

  function automatic logic [2:0] len_bits(input logic [4:0] idx);
    priority if (idx >= 5'd28)      len_bits = 3'd0;
    else if (idx >= 5'd8)           len_bits = 3'(((idx - 5'd8) >> 2) + 5'd1);
    else                            len_bits = 3'd0;
  endfunction

  function automatic logic [DIST_W-2:0] dist_base(input logic [DSYM_W-1:0] idx);
    unique case (idx)
      5'd0:  dist_base = 15'd1;     5'd1:  dist_base = 15'd2;
      5'd2:  dist_base = 15'd3;     5'd3:  dist_base = 15'd4;
      5'd4:  dist_base = 15'd5;     5'd5:  dist_base = 15'd7;
      5'd6:  dist_base = 15'd9;     5'd7:  dist_base = 15'd13;
      5'd8:  dist_base = 15'd17;    5'd9:  dist_base = 15'd25;
      5'd10: dist_base = 15'd33;    5'd11: dist_base = 15'd49;
      5'd12: dist_base = 15'd65;    5'd13: dist_base = 15'd97;
      5'd14: dist_base = 15'd129;   5'd15: dist_base = 15'd193;
      5'd16: dist_base = 15'd257;   5'd17: dist_base = 15'd385;
      5'd18: dist_base = 15'd513;   5'd19: dist_base = 15'd769;
      5'd20: dist_base = 15'd1025;  5'd21: dist_base = 15'd1537;
      5'd22: dist_base = 15'd2049;  5'd23: dist_base = 15'd3073;
      5'd24: dist_base = 15'd4097;  5'd25: dist_base = 15'd6145;
      5'd26: dist_base = 15'd8193;  5'd27: dist_base = 15'd12289;
      5'd28: dist_base = 15'd16385; 5'd29: dist_base = 15'd24577;
      default: dist_base = 15'd0;
    endcase
  endfunction

  function automatic logic [3:0] dist_bits(input logic [DSYM_W-1:0] idx);
    priority if (idx >= NUM_DIST_SYM) dist_bits = 4'd0;
    else if (idx >= 5'd4)             dist_bits = 4'((idx >> 1) - 5'd1);
    else                              dist_bits = 4'd0;
  endfunction

endpackage

// ===== rtl/dmc_ctrl.sv =====
// Controller: sequences accept, decode, range check, byte copy and single results.
module dmc_ctrl import dmc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dmc_stat_t stat,
  output dmc_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_COPY   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   inflight, inflight_next;

  // Copy pipeline: catch the byte in flight unless its group cannot flush yet
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_next    = state;
    inflight_next = inflight;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = (stat.is_literal || stat.single) ? S_EMIT : S_CHECK;
      end
      S_CHECK: begin
        cmd.check     = 1'b1;
        inflight_next = 1'b0;
        state_next    = stat.too_far ? S_EMIT : S_COPY;
      end
      S_COPY: begin
        cmd.take  = inflight && (!stat.catch_flush || stat.out_free);
        cmd.issue = stat.issue_left && (!inflight || cmd.take);
        if (cmd.issue)     inflight_next = 1'b1;
        else if (cmd.take) inflight_next = 1'b0;
        if (cmd.take && stat.catch_final) state_next = S_IDLE;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      inflight <= 1'b0;
    end else begin
      state    <= state_next;
      inflight <= inflight_next;
    end
  end

endmodule

// ===== rtl/dmc_datapath.sv =====
// Datapath: item registers, code tables, history memory, pointers and output register.
module dmc_datapath import dmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dmc_cmd_t                cmd,
  output dmc_stat_t               stat,
  input  logic                    in_command,
  input  logic [IN_DATA_W-1:0]    in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_BYTES_W-1:0]  out_bytes,
  output logic [BYTE_CNT_W-1:0]   byte_count,
  output logic                    last_of_item,
  output err_t                    error_code
);

  // Held request fields
  logic              item_cmd;
  logic [LIT_W-1:0]  item_lit;
  logic [LSYM_W-1:0] item_lsym;
  logic [LEXT_W-1:0] item_lext;
  logic [DSYM_W-1:0] item_dsym;
  logic [DEXT_W-1:0] item_dext;

  // Decoded match
  logic [LEN_W-1:0]  length;
  logic [DIST_W-1:0] distance;
  err_t              err_reg;

  // Window state
  logic [ADDR_W-1:0]  wp;
  logic [COUNT_W-1:0] produced;
  logic [ADDR_W-1:0]  rd_ptr;

  // Copy state
  logic [LEN_W-1:0]  issued;
  logic [LEN_W-1:0]  caught;
  logic [LANE_W-1:0] lane;
  logic [BYTES_PER_RESULT-1:0][LIT_W-1:0] acc;
  logic [BYTES_PER_RESULT-1:0][LIT_W-1:0] acc_full;

  // History memory with registered read and same-address bypass
  logic [LIT_W-1:0] hist [WINDOW_SIZE];
  logic [LIT_W-1:0] mem_q;
  logic             byp;
  logic [LIT_W-1:0] byp_data;
  logic [LIT_W-1:0] catch_byte;
  logic             wr_en;
  logic [LIT_W-1:0] wr_data;

  // Decode signals
  logic [4:0]          lidx;
  logic [2:0]          lbits;
  logic [3:0]          dbits;
  logic [LEN_W-1:0]    len_calc;
  logic [DIST_W-1:0]   dist_calc;
  logic                is_eob, bad_len, bad_dist;
  logic [DIST_W:0]     start_calc;

  assign lidx      = 5'(item_lsym - SYM_LEN_FIRST);
  assign lbits     = len_bits(lidx);
  assign dbits     = dist_bits(item_dsym);
  assign len_calc  = len_base(lidx) + LEN_W'(item_lext & ~({LEXT_W{1'b1}} << lbits));
  assign dist_calc = DIST_W'(dist_base(item_dsym)) +
                     DIST_W'(item_dext & ~({DEXT_W{1'b1}} << dbits));
  assign is_eob    = (item_lsym == SYM_EOB);
  assign bad_len   = !is_eob && ((item_lsym < SYM_LEN_FIRST) || (item_lsym > SYM_LEN_LAST));
  assign bad_dist  = (item_dsym >= NUM_DIST_SYM);

  // Start address of the copy, wrapped into the window
  always_comb begin
    if ({1'b0, wp} >= distance)
      start_calc = (DIST_W+1)'(wp) - (DIST_W+1)'(distance);
    else
      start_calc = (DIST_W+1)'(wp) + (DIST_W+1)'(WINDOW_SIZE) - (DIST_W+1)'(distance);
  end

  assign catch_byte = byp ? byp_data : mem_q;

  always_comb begin
    acc_full       = acc;
    acc_full[lane] = catch_byte;
  end

  // Status toward the controller
  always_comb begin
    stat             = '0;
    stat.is_literal  = (item_cmd == CMD_LITERAL);
    stat.single      = (item_cmd == CMD_MATCH) && (is_eob || bad_len || bad_dist);
    stat.too_far     = (distance > DIST_W'(produced));
    stat.issue_left  = (issued != length);
    stat.catch_final = ((caught + 1'b1) == length);
    stat.catch_flush = stat.catch_final || (lane == LANE_W'(BYTES_PER_RESULT - 1));
    stat.out_free    = !out_valid || out_ready;
  end

  assign wr_en   = cmd.take || (cmd.emit && item_cmd == CMD_LITERAL);
  assign wr_data = cmd.take ? catch_byte : item_lit;

  // Write and read the history
  always_ff @(posedge clk) begin
    if (wr_en) hist[wp] <= wr_data;
    if (cmd.issue) mem_q <= hist[rd_ptr];
  end

  // Capture request fields and decode
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd  <= in_command;
      item_lit  <= in_data[7:0];
      item_lsym <= in_data[16:8];
      item_lext <= in_data[21:17];
      item_dsym <= in_data[26:22];
      item_dext <= in_data[39:27];
    end
    if (cmd.decode) begin
      length   <= len_calc;
      distance <= dist_calc;
      priority if (bad_len) err_reg <= ERR_LEN;
      else if (!is_eob && bad_dist) err_reg <= ERR_DIST;
      else err_reg <= ERR_NONE;
    end
    if (cmd.check && stat.too_far) err_reg <= ERR_FAR;
  end

  // Copy counters, read pointer and byte gathering
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rd_ptr <= ADDR_W'(start_calc);
      issued <= '0;
      caught <= '0;
      lane   <= '0;
      acc    <= '0;
    end else begin
      if (cmd.issue) begin
        rd_ptr   <= ptr_inc(rd_ptr);
        issued   <= issued + 1'b1;
        byp      <= cmd.take && (rd_ptr == wp);
        byp_data <= catch_byte;
      end
      if (cmd.take) begin
        caught <= caught + 1'b1;
        if (stat.catch_flush) begin
          lane <= '0;
          acc  <= '0;
        end else begin
          lane <= lane + 1'b1;
          acc  <= acc_full;
        end
      end
    end
  end

  // Advance write pointer and produced count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      produced <= '0;
    end else if (wr_en) begin
      wp <= ptr_inc(wp);
      if (produced < COUNT_W'(WINDOW_SIZE)) produced <= produced + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || (cmd.take && stat.catch_flush)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_of_item <= 1'b1;
      if (item_cmd == CMD_LITERAL) begin
        out_bytes  <= OUT_BYTES_W'(item_lit);
        byte_count <= BYTE_CNT_W'(1);
        error_code <= ERR_NONE;
      end else begin
        out_bytes  <= '0;
        byte_count <= '0;
        error_code <= err_reg;
      end
    end else if (cmd.take && stat.catch_flush) begin
      out_bytes    <= OUT_BYTES_W'(acc_full);
      byte_count   <= BYTE_CNT_W'(lane) + 1'b1;
      last_of_item <= stat.catch_final;
      error_code   <= ERR_NONE;
    end
  end

endmodule

// ===== rtl/deflate_match_copy_top.sv =====
// Literal, end-of-block and bad-symbol requests pass through DECODE and EMIT; EMIT loads the result
// register once the output is free, and the request after it is taken back in IDLE.
// A too-far distance adds a CHECK state before EMIT. A match of length bytes goes through
// DECODE, CHECK and COPY, loads its last result and returns to IDLE for the request after it;
// copying moves one history byte per cycle and stalls only while a full or final partial result waits.
// rst (synchronous) clears pointer, produced count and control; history is not cleared.
module deflate_match_copy_top import dmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] literal_byte, [16:8] length_symbol, [21:17] length_extra,
  // [26:22] dist_code, [39:27] distance_extra
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_of_item
  output logic                  m_axis_tlast,
  // [1:0] error_code
  output logic [1:0]            m_axis_tuser
);

  dmc_cmd_t                cmd;
  dmc_stat_t               stat;
  logic [OUT_BYTES_W-1:0]  out_bytes;
  logic [BYTE_CNT_W-1:0]   byte_count;
  err_t                    error_code;

  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (s_axis_tuser),
    .in_data      (s_axis_tdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_bytes    (out_bytes),
    .byte_count   (byte_count),
    .last_of_item (m_axis_tlast),
    .error_code   (error_code)
  );

  // Pack result fields
  assign m_axis_tdata = {(OUT_DATA_W - OUT_BYTES_W - BYTE_CNT_W)'(0), byte_count, out_bytes};
  assign m_axis_tuser = error_code;

endmodule

// ===== rtl/dmc_chk.sv =====
// Checker: port-level properties of the match copy block, bound to the top level.
module dmc_chk import dmc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic [1:0]            m_axis_tuser
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Error results are empty and close the request
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ERR_NONE |-> m_axis_tdata[67:64] == 4'd0 && m_axis_tlast)
    else $error("error result carries bytes");

  // Results before the last one are full and clean
  a_full_mid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      m_axis_tdata[67:64] == BYTE_CNT_W'(BYTES_PER_RESULT) && m_axis_tuser == ERR_NONE)
    else $error("partial result before last");

  // No result directly out of reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind deflate_match_copy_top dmc_chk u_dmc_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
